// ===== hdl/kct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kct_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ENTER  = 3'd1,
        PH_READY  = 3'd2,
        PH_RUN    = 3'd3,
        PH_PAUSE  = 3'd4,
        PH_TIMEUP = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        STEP_MINUTE = 2'd0,
        STEP_TENS   = 2'd1,
        STEP_ONES   = 2'd2
    } entry_step_t;

    typedef enum logic [0:0] {
        OP_KEY  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // keypad positions, row*4+col on 123A 456B 789C *0#D
    localparam logic [3:0] KEY_POS_A = 4'd3;
    localparam logic [3:0] KEY_POS_B = 4'd7;
    localparam logic [3:0] KEY_POS_D = 4'd15;

    localparam logic [3:0] DIGIT_MAX      = 4'd9;
    localparam logic [2:0] TENS_MAX       = 3'd5;
    localparam logic [3:0] TENS_ENTRY_MAX = 4'd5;

    typedef struct packed {
        phase_t      phase;
        entry_step_t step;
        logic [3:0]  minute;
        logic [2:0]  tens;
        logic [3:0]  ones;
        logic        alarm;
    } timer_state_t;

    typedef struct packed {
        logic       is_digit;
        logic [3:0] value;
    } key_digit_t;

    function automatic key_digit_t decode_digit(input logic [3:0] pos);
        key_digit_t d;
        d.is_digit = 1'b1;
        case (pos)
            4'd0:    d.value = 4'd1;
            4'd1:    d.value = 4'd2;
            4'd2:    d.value = 4'd3;
            4'd4:    d.value = 4'd4;
            4'd5:    d.value = 4'd5;
            4'd6:    d.value = 4'd6;
            4'd8:    d.value = 4'd7;
            4'd9:    d.value = 4'd8;
            4'd10:   d.value = 4'd9;
            4'd13:   d.value = 4'd0;
            default:
            begin
                d.is_digit = 1'b0;
                d.value    = 4'd0;
            end
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/kct_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kct_step
    import kct_pkg::*;
(
    input  timer_state_t cur,
    input  logic         operation,
    input  logic [3:0]   key_position,
    output timer_state_t nxt
);

    key_digit_t dig;

    always_comb
    begin
        dig = decode_digit(key_position);
        nxt = cur;
        if (operation == OP_TICK)
        begin
            if (cur.phase == PH_RUN)
            begin
                if (cur.minute == 4'd0 && cur.tens == 3'd0 && cur.ones == 4'd0)
                begin
                    nxt.phase = PH_TIMEUP;
                    nxt.alarm = 1'b1;
                end
                else if (cur.ones != 4'd0)
                begin
                    nxt.ones = cur.ones - 4'd1;
                end
                else
                begin
                    // borrow from tens, then from minutes
                    nxt.ones = DIGIT_MAX;
                    if (cur.tens != 3'd0)
                    begin
                        nxt.tens = cur.tens - 3'd1;
                    end
                    else
                    begin
                        nxt.tens   = TENS_MAX;
                        nxt.minute = cur.minute - 4'd1;
                    end
                end
            end
        end
        else if (key_position == KEY_POS_D)
        begin
            nxt.phase = PH_ENTER;
            nxt.step  = STEP_MINUTE;
            nxt.alarm = 1'b0;
        end
        else
        begin
            case (cur.phase)
                PH_ENTER:
                begin
                    case (cur.step)
                        STEP_MINUTE:
                        begin
                            if (dig.is_digit)
                            begin
                                nxt.minute = dig.value;
                                nxt.step   = STEP_TENS;
                            end
                        end
                        STEP_TENS:
                        begin
                            if (dig.is_digit && dig.value <= TENS_ENTRY_MAX)
                            begin
                                nxt.tens = dig.value[2:0];
                                nxt.step = STEP_ONES;
                            end
                        end
                        default:
                        begin
                            if (dig.is_digit)
                            begin
                                nxt.ones  = dig.value;
                                nxt.step  = STEP_MINUTE;
                                nxt.phase = PH_READY;
                            end
                        end
                    endcase
                end
                PH_READY, PH_PAUSE:
                begin
                    if (key_position == KEY_POS_A)
                    begin
                        nxt.phase = PH_RUN;
                    end
                end
                PH_RUN:
                begin
                    if (key_position == KEY_POS_B)
                    begin
                        nxt.phase = PH_PAUSE;
                    end
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/keypad_countdown_timer.sv =====
// Keypad countdown timer, m:ss in BCD digits.
// Items pass the input register, then a single pass of next-state logic into the result register.
// Throughput: one item per cycle unless out_stall holds back a full result register.
// in_stall rises only while the result register is full and out_stall holds it.
// Reset (rst_n low, asynchronous): state phase idle, time 0:00, entry at minute, alarm off.
`timescale 1ns / 1ps
`default_nettype none

module keypad_countdown_timer
    import kct_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       operation,
    input  wire logic [3:0] key_position,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [3:0]      minutes,
    output logic [2:0]      seconds_tens,
    output logic [3:0]      seconds_ones,
    output logic [2:0]      phase,
    output logic [1:0]      entry_step,
    output logic            alarm_led
);

    logic         in_full_reg;
    logic         op_reg;
    logic [3:0]   key_reg;
    logic         out_full_reg;
    timer_state_t state_reg;
    timer_state_t state_next;
    logic [3:0]   minutes_reg;
    logic [2:0]   tens_reg;
    logic [3:0]   ones_reg;
    logic [2:0]   phase_reg;
    logic [1:0]   step_reg;
    logic         alarm_reg;
    logic         advance;

    // move the held item into the result register when that slot frees up
    assign advance  = in_full_reg && (!out_full_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;

    kct_step u_step (
        .cur          (state_reg),
        .operation    (op_reg),
        .key_position (key_reg),
        .nxt          (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
            state_reg    <= '{phase: PH_IDLE, step: STEP_MINUTE, minute: 4'd0,
                              tens: 3'd0, ones: 4'd0, alarm: 1'b0};
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_full_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_full_reg <= 1'b0;
            end

            if (advance)
            begin
                out_full_reg <= 1'b1;
                state_reg    <= state_next;
            end
            else if (!out_stall)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg  <= operation;
            key_reg <= key_position;
        end
        if (advance)
        begin
            minutes_reg <= state_next.minute;
            tens_reg    <= state_next.tens;
            ones_reg    <= state_next.ones;
            phase_reg   <= state_next.phase;
            step_reg    <= (state_next.phase == PH_ENTER) ? state_next.step : STEP_MINUTE;
            alarm_reg   <= state_next.alarm;
        end
    end

    assign out_valid    = out_full_reg;
    assign minutes      = minutes_reg;
    assign seconds_tens = tens_reg;
    assign seconds_ones = ones_reg;
    assign phase        = phase_reg;
    assign entry_step   = step_reg;
    assign alarm_led    = alarm_reg;

endmodule

`default_nettype wire

// ===== tb/sv/keypad_countdown_timer_test.sv =====
`timescale 1ns / 1ps

module keypad_countdown_timer_test;
    import kct_pkg::*;

    localparam logic [3:0] POS_STAR = 4'd12;
    localparam logic [3:0] POS_HASH = 4'd14;
    // keypad position of each decimal digit
    localparam logic [3:0] DIGIT_POS [10] = '{4'd13, 4'd0, 4'd1, 4'd2, 4'd4,
                                              4'd5, 4'd6, 4'd8, 4'd9, 4'd10};
    localparam int ITEM_COUNT = 1600;

    typedef struct {
        op_t          op;
        logic [3:0]   pos;
        bit           typed;
        timer_state_t want;
    } script_row_t;

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic       operation    = 1'b0;
    logic [3:0] key_position = 4'd0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [3:0] minutes;
    logic [2:0] seconds_tens;
    logic [3:0] seconds_ones;
    logic [2:0] phase;
    logic [1:0] entry_step;
    logic       alarm_led;

    timer_state_t pending_readouts[$];
    timer_state_t timer_now;
    script_row_t  script [26];

    int errors           = 0;
    int readouts_checked = 0;
    int active_items     = 0;
    int keys_sent        = 0;
    int ticks_sent       = 0;
    int alarms_raised    = 0;
    int burst_left       = 0;
    int stall_left       = 0;
    int stall_mode       = 0;

    keypad_countdown_timer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .key_position (key_position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .minutes      (minutes),
        .seconds_tens (seconds_tens),
        .seconds_ones (seconds_ones),
        .phase        (phase),
        .entry_step   (entry_step),
        .alarm_led    (alarm_led)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("keypad_countdown_timer_test failed");
        $finish;
    end

    function automatic timer_state_t advance_timer(timer_state_t s, op_t op,
                                                   logic [3:0] pos);
        int digit;
        digit = -1;
        for (int d = 0; d < 10; d++)
        begin
            if (DIGIT_POS[d] == pos)
                digit = d;
        end
        if (op == OP_TICK)
        begin
            if (s.phase == PH_RUN)
            begin
                if (s.minute == 0 && s.tens == 0 && s.ones == 0)
                begin
                    s.phase = PH_TIMEUP;
                    s.alarm = 1'b1;
                end
                else if (s.ones != 0)
                    s.ones = s.ones - 4'd1;
                else
                begin
                    // borrow from tens, then from minutes
                    s.ones = DIGIT_MAX;
                    if (s.tens != 0)
                        s.tens = s.tens - 3'd1;
                    else
                    begin
                        s.tens   = TENS_MAX;
                        s.minute = s.minute - 4'd1;
                    end
                end
            end
        end
        else if (pos == KEY_POS_D)
        begin
            s.phase = PH_ENTER;
            s.step  = STEP_MINUTE;
            s.alarm = 1'b0;
        end
        else if (s.phase == PH_ENTER)
        begin
            if (digit >= 0)
            begin
                case (s.step)
                    STEP_MINUTE:
                    begin
                        s.minute = 4'(digit);
                        s.step   = STEP_TENS;
                    end
                    STEP_TENS:
                    begin
                        if (digit <= TENS_MAX)
                        begin
                            s.tens = 3'(digit);
                            s.step = STEP_ONES;
                        end
                    end
                    default:
                    begin
                        s.ones  = 4'(digit);
                        s.step  = STEP_MINUTE;
                        s.phase = PH_READY;
                    end
                endcase
            end
        end
        else if ((s.phase == PH_READY || s.phase == PH_PAUSE) && pos == KEY_POS_A)
            s.phase = PH_RUN;
        else if (s.phase == PH_RUN && pos == KEY_POS_B)
            s.phase = PH_PAUSE;
        return s;
    endfunction

    task automatic send_event(input op_t op, input logic [3:0] pos, input bit typed,
                              input timer_state_t want);
        timer_state_t next;
        in_valid     <= 1'b1;
        operation    <= op;
        key_position <= pos;
        do
            @(posedge clk);
        while (in_stall);

        next = advance_timer(timer_now, op, pos);
        if (next != timer_now)
            active_items++;
        if (next.alarm && !timer_now.alarm)
            alarms_raised++;
        if (op == OP_TICK)
            ticks_sent++;
        else
            keys_sent++;
        timer_now = next;
        if (timer_now.phase != PH_ENTER)
            next.step = STEP_MINUTE;
        pending_readouts.push_back(typed ? want : next);

        // sender works in bursts; drop valid during a gap
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic press(input logic [3:0] pos);
        send_event(OP_KEY, pos, 1'b0, '0);
    endtask

    task automatic tick();
        send_event(OP_TICK, 4'($urandom_range(0, 15)), 1'b0, '0);
    endtask

    // one countdown: enter a time, then mostly start it and tick it down, with pauses and stray keys
    task automatic run_countdown();
        int pick;
        int m;
        int t;
        int o;
        int ticks;
        pick = $urandom_range(0, 99);
        m = (pick < 70) ? 0 : (pick < 92) ? $urandom_range(1, 2) : $urandom_range(3, 9);
        t = $urandom_range(0, 5);
        o = $urandom_range(0, 9);
        press(KEY_POS_D);
        if ($urandom_range(0, 9) == 0)
            press(4'($urandom_range(0, 14)));
        press(DIGIT_POS[m]);
        if ($urandom_range(0, 6) == 0)
            press(DIGIT_POS[$urandom_range(6, 9)]);
        press(DIGIT_POS[t]);
        if ($urandom_range(0, 9) == 0)
            press(($urandom_range(0, 1) == 0) ? POS_STAR : KEY_POS_A);
        press(DIGIT_POS[o]);
        // abandon this one now and then; the next countdown re-enters
        if ($urandom_range(0, 7) == 0)
            return;
        press(KEY_POS_A);
        ticks = m * 60 + t * 10 + o + 1 + $urandom_range(0, 2);
        repeat (ticks)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                press(KEY_POS_B);
                repeat ($urandom_range(0, 3)) tick();
                press(KEY_POS_A);
            end
            else if (pick < 7)
                press(4'($urandom_range(0, 14)));
            tick();
        end
        if ($urandom_range(0, 4) == 0)
        begin
            press(KEY_POS_A);
            tick();
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 9) < 3);
            2:       out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= stall_left[2];
        endcase
    end

    always @(posedge clk)
    begin
        timer_state_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readouts.size() == 0)
            begin
                errors++;
                $display("%0t: readout with nothing expected, got %0d %0d:%0d%0d", $time,
                         phase, minutes, seconds_tens, seconds_ones);
            end
            else
            begin
                want = pending_readouts.pop_front();
                readouts_checked++;
                check_field("minutes", want.minute, minutes);
                check_field("seconds_tens", want.tens, seconds_tens);
                check_field("seconds_ones", want.ones, seconds_ones);
                check_field("phase", want.phase, phase);
                check_field("entry_step", want.step, entry_step);
                check_field("alarm_led", want.alarm, alarm_led);
            end
        end
    end

    initial
    begin
        script = '{
            '{OP_TICK, 4'd0,         1'b1, '{PH_IDLE,   STEP_MINUTE, 4'd0, 3'd0, 4'd0, 1'b0}},
            '{OP_KEY,  KEY_POS_A,    1'b1, '{PH_IDLE,   STEP_MINUTE, 4'd0, 3'd0, 4'd0, 1'b0}},
            '{OP_KEY,  KEY_POS_D,    1'b1, '{PH_ENTER,  STEP_MINUTE, 4'd0, 3'd0, 4'd0, 1'b0}},
            '{OP_KEY,  POS_STAR,     1'b1, '{PH_ENTER,  STEP_MINUTE, 4'd0, 3'd0, 4'd0, 1'b0}},
            '{OP_KEY,  DIGIT_POS[9], 1'b1, '{PH_ENTER,  STEP_TENS,   4'd9, 3'd0, 4'd0, 1'b0}},
            '{OP_KEY,  DIGIT_POS[6], 1'b1, '{PH_ENTER,  STEP_TENS,   4'd9, 3'd0, 4'd0, 1'b0}},
            '{OP_KEY,  DIGIT_POS[5], 1'b1, '{PH_ENTER,  STEP_ONES,   4'd9, 3'd5, 4'd0, 1'b0}},
            '{OP_KEY,  KEY_POS_D,    1'b1, '{PH_ENTER,  STEP_MINUTE, 4'd9, 3'd5, 4'd0, 1'b0}},
            '{OP_KEY,  DIGIT_POS[1], 1'b1, '{PH_ENTER,  STEP_TENS,   4'd1, 3'd5, 4'd0, 1'b0}},
            '{OP_KEY,  DIGIT_POS[0], 1'b1, '{PH_ENTER,  STEP_ONES,   4'd1, 3'd0, 4'd0, 1'b0}},
            '{OP_KEY,  POS_HASH,     1'b0, '0},
            '{OP_KEY,  DIGIT_POS[0], 1'b1, '{PH_READY,  STEP_MINUTE, 4'd1, 3'd0, 4'd0, 1'b0}},
            '{OP_TICK, 4'd9,         1'b0, '0},
            '{OP_KEY,  KEY_POS_A,    1'b1, '{PH_RUN,    STEP_MINUTE, 4'd1, 3'd0, 4'd0, 1'b0}},
            '{OP_TICK, 4'd5,         1'b1, '{PH_RUN,    STEP_MINUTE, 4'd0, 3'd5, 4'd9, 1'b0}},
            '{OP_KEY,  KEY_POS_B,    1'b1, '{PH_PAUSE,  STEP_MINUTE, 4'd0, 3'd5, 4'd9, 1'b0}},
            '{OP_KEY,  KEY_POS_A,    1'b0, '0},
            '{OP_KEY,  KEY_POS_D,    1'b1, '{PH_ENTER,  STEP_MINUTE, 4'd0, 3'd5, 4'd9, 1'b0}},
            '{OP_KEY,  DIGIT_POS[0], 1'b1, '{PH_ENTER,  STEP_TENS,   4'd0, 3'd5, 4'd9, 1'b0}},
            '{OP_KEY,  DIGIT_POS[0], 1'b1, '{PH_ENTER,  STEP_ONES,   4'd0, 3'd0, 4'd9, 1'b0}},
            '{OP_KEY,  DIGIT_POS[1], 1'b1, '{PH_READY,  STEP_MINUTE, 4'd0, 3'd0, 4'd1, 1'b0}},
            '{OP_KEY,  KEY_POS_A,    1'b1, '{PH_RUN,    STEP_MINUTE, 4'd0, 3'd0, 4'd1, 1'b0}},
            '{OP_TICK, KEY_POS_D,    1'b1, '{PH_RUN,    STEP_MINUTE, 4'd0, 3'd0, 4'd0, 1'b0}},
            '{OP_TICK, 4'd15,        1'b1, '{PH_TIMEUP, STEP_MINUTE, 4'd0, 3'd0, 4'd0, 1'b1}},
            '{OP_KEY,  KEY_POS_A,    1'b1, '{PH_TIMEUP, STEP_MINUTE, 4'd0, 3'd0, 4'd0, 1'b1}},
            '{OP_KEY,  KEY_POS_D,    1'b1, '{PH_ENTER,  STEP_MINUTE, 4'd0, 3'd0, 4'd0, 1'b0}}
        };
        timer_now = '{PH_IDLE, STEP_MINUTE, 4'd0, 3'd0, 4'd0, 1'b0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_event(script[i].op, script[i].pos, script[i].typed, script[i].want);

        while (keys_sent + ticks_sent < ITEM_COUNT)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 10))
                    send_event(op_t'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                               1'b0, '0);
            end
            run_countdown();
            // hold off until every readout is back
            if ($urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_readouts.size() != 0);
            end
        end

        in_valid <= 1'b0;
        while (pending_readouts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d key presses and %0d ticks, %0d changing the timer state.",
                 keys_sent, ticks_sent, active_items);
        $display("Checked %0d readouts; the alarm went off %0d times.",
                 readouts_checked, alarms_raised);
        if (errors == 0)
            $display("keypad_countdown_timer_test passed");
        else
            $display("keypad_countdown_timer_test failed");
        $finish;
    end

endmodule
